// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MKP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mkp assertion failed");

// next-cycle implication
`define MKP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mkp assertion failed");

`else

`define MKP_ASSERT_IMP(label, clk, rst, ante, cons)
`define MKP_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/mkp_pkg.sv =====
// ----------------------------------------------------------------------------
// mkp_pkg
// shared constants, types and helpers of the key partitioner
// ----------------------------------------------------------------------------
`default_nettype none

package mkp_pkg;

  localparam int KEY_BYTES = 8;
  localparam int KEY_LEN   = (KEY_BYTES > 8) ? 8 : KEY_BYTES;
  localparam int KEY_W     = 64;
  localparam int HASH_W    = 32;
  localparam int LANES     = KEY_W / HASH_W;
  localparam int NBLK      = KEY_LEN / 4;
  localparam int TAIL      = KEY_LEN % 4;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_LEN >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_LEN)) - 64'd1);
  localparam logic [HASH_W-1:0] LEN_WORD = HASH_W'(KEY_LEN);

  localparam logic [HASH_W-1:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [HASH_W-1:0] MM_C2 = 32'h1b873593;
  localparam logic [HASH_W-1:0] MM_N  = 32'he6546b64;
  localparam logic [HASH_W-1:0] MM_F1 = 32'h85ebca6b;
  localparam logic [HASH_W-1:0] MM_F2 = 32'hc2b2ae35;

  localparam int CNT_W     = 9;
  localparam int OWN_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [HASH_W-1:0] SEED_RESET  = 32'h9747b28c;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 9'd1;
  localparam logic [OWN_W-1:0]  LOCAL_RESET = 8'd0;

  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = HASH_W / DIV_BITS;
  localparam int HASH_STAGES = 2 + LANES + 3;
  localparam int LATENCY     = HASH_STAGES + DIV_STAGES + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_SEED    = 2'd0,
    REG_CLIENT_COUNT = 2'd1,
    REG_LOCAL_INDEX  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              vld;
    logic [HASH_W-1:0] hash;
  } hash_beat_t;

  typedef struct packed {
    logic              vld;
    logic [HASH_W-1:0] hash;
    logic [OWN_W-1:0]  rem;
  } rem_beat_t;

  function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x, input int r);
    return (x << r) | (x >> (HASH_W - r));
  endfunction

  // one restoring step of the remainder, divisor 1..256
  function automatic logic [OWN_W-1:0] rem_step(input logic [OWN_W-1:0] r, input logic b,
                                                input logic [CNT_W-1:0] d);
    logic [CNT_W-1:0] t;
    t = {r, b};
    if (t >= d) begin
      t = t - d;
    end
    return t[OWN_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mkp_hash.sv =====
// ----------------------------------------------------------------------------
// mkp_hash
// pipelined 32-bit murmur3 of one fixed-length key per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mkp_hash (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_vld,
  input  wire logic [mkp_pkg::KEY_W-1:0]    key_bytes,
  input  wire logic [mkp_pkg::HASH_W-1:0]   seed,
  output mkp_pkg::hash_beat_t               out
);

  logic [mkp_pkg::KEY_W-1:0]  key_m;
  logic [mkp_pkg::HASH_W-1:0] mul1 [mkp_pkg::LANES];
  logic                       v1;
  logic [mkp_pkg::HASH_W-1:0] scr [mkp_pkg::LANES];
  logic                       v2;

  logic [mkp_pkg::HASH_W-1:0] mix_h   [mkp_pkg::LANES+1];
  logic [mkp_pkg::HASH_W-1:0] mix_scr [mkp_pkg::LANES+1][mkp_pkg::LANES];
  logic                       mix_v   [mkp_pkg::LANES+1];

  logic [mkp_pkg::HASH_W-1:0] f1;
  logic                       fv1;
  logic [mkp_pkg::HASH_W-1:0] f2;
  logic                       fv2;
  logic [mkp_pkg::HASH_W-1:0] hash;
  logic                       hv;

  logic [mkp_pkg::HASH_W-1:0] fin_a;
  logic [mkp_pkg::HASH_W-1:0] fin_b;

  assign key_m = key_bytes & mkp_pkg::KEY_MASK;

  // block scramble, first multiply
  always_ff @(posedge clk) begin
    for (int w = 0; w < mkp_pkg::LANES; w++) begin
      mul1[w] <= key_m[w*mkp_pkg::HASH_W +: mkp_pkg::HASH_W] * mkp_pkg::MM_C1;
    end
  end

  // block scramble, second multiply
  always_ff @(posedge clk) begin
    for (int w = 0; w < mkp_pkg::LANES; w++) begin
      scr[w] <= mkp_pkg::rotl(mul1[w], 15) * mkp_pkg::MM_C2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
    end
  end

  always_comb begin
    mix_h[0]   = seed;
    mix_v[0]   = v2;
    mix_scr[0] = scr;
  end

  // one mix stage per key word
  for (genvar w = 0; w < mkp_pkg::LANES; w++) begin : g_mix
    logic [mkp_pkg::HASH_W-1:0] h_x;
    logic [mkp_pkg::HASH_W-1:0] h_r;
    logic [mkp_pkg::HASH_W-1:0] h_next;

    always_comb begin
      h_x = mix_h[w] ^ mix_scr[w][w];
      h_r = mkp_pkg::rotl(h_x, 13);
      if (w < mkp_pkg::NBLK) begin
        h_next = h_r + (h_r << 2) + mkp_pkg::MM_N;
      end else if (w == mkp_pkg::NBLK && mkp_pkg::TAIL != 0) begin
        h_next = h_x;
      end else begin
        h_next = mix_h[w];
      end
    end

    always_ff @(posedge clk) begin
      mix_h[w+1]   <= h_next;
      mix_scr[w+1] <= mix_scr[w];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mix_v[w+1] <= 1'b0;
      end else begin
        mix_v[w+1] <= mix_v[w];
      end
    end
  end

  // finalizer
  always_comb begin
    fin_a = mix_h[mkp_pkg::LANES] ^ mkp_pkg::LEN_WORD;
    fin_a = fin_a ^ (fin_a >> 16);
    fin_b = f1 ^ (f1 >> 13);
  end

  always_ff @(posedge clk) begin
    f1   <= fin_a * mkp_pkg::MM_F1;
    f2   <= fin_b * mkp_pkg::MM_F2;
    hash <= f2 ^ (f2 >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv1 <= 1'b0;
      fv2 <= 1'b0;
      hv  <= 1'b0;
    end else begin
      fv1 <= mix_v[mkp_pkg::LANES];
      fv2 <= fv1;
      hv  <= fv2;
    end
  end

  assign out.vld  = hv;
  assign out.hash = hash;

endmodule

`default_nettype wire

// ===== hw/rtl/mkp_rem.sv =====
// ----------------------------------------------------------------------------
// mkp_rem
// pipelined restoring remainder of the hash by the partition count
// ----------------------------------------------------------------------------
`default_nettype none

module mkp_rem (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mkp_pkg::hash_beat_t         in,
  input  wire logic [mkp_pkg::CNT_W-1:0]   divisor,
  output mkp_pkg::rem_beat_t               out
);

  logic                       st_v [mkp_pkg::DIV_STAGES+1];
  logic [mkp_pkg::HASH_W-1:0] st_h [mkp_pkg::DIV_STAGES+1];
  logic [mkp_pkg::OWN_W-1:0]  st_r [mkp_pkg::DIV_STAGES+1];

  always_comb begin
    st_v[0] = in.vld;
    st_h[0] = in.hash;
    st_r[0] = '0;
  end

  // four quotient bits per stage, msb first
  for (genvar s = 0; s < mkp_pkg::DIV_STAGES; s++) begin : g_div
    logic [mkp_pkg::OWN_W-1:0]  r_next;
    logic [mkp_pkg::HASH_W-1:0] bits;

    always_comb begin
      r_next = st_r[s];
      bits   = st_h[s] << (s * mkp_pkg::DIV_BITS);
      for (int j = 0; j < mkp_pkg::DIV_BITS; j++) begin
        r_next = mkp_pkg::rem_step(r_next, bits[mkp_pkg::HASH_W-1], divisor);
        bits   = bits << 1;
      end
    end

    always_ff @(posedge clk) begin
      st_h[s+1] <= st_h[s];
      st_r[s+1] <= r_next;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[s+1] <= 1'b0;
      end else begin
        st_v[s+1] <= st_v[s];
      end
    end
  end

  assign out.vld  = st_v[mkp_pkg::DIV_STAGES];
  assign out.hash = st_h[mkp_pkg::DIV_STAGES];
  assign out.rem  = st_r[mkp_pkg::DIV_STAGES];

endmodule

`default_nettype wire

// ===== hw/rtl/murmur3_key_partitioner.sv =====
// ----------------------------------------------------------------------------
// murmur3_key_partitioner
// done rises after a taken key passes the hash, remainder and output registers
// throughput: one key per cycle, busy stays low; set by the fully pipelined
// multiply and remainder stages
// reset: clears all valid bits, seed 0x9747b28c, client count 1, local index 0
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module murmur3_key_partitioner (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [mkp_pkg::KEY_W-1:0]       key_bytes,
  output logic                                 done,
  output logic [mkp_pkg::HASH_W-1:0]           hash_value,
  output logic [mkp_pkg::OWN_W-1:0]            owner_index,
  output logic                                 is_local,
  input  wire logic                            cfg_we,
  input  wire logic [mkp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mkp_pkg::CFG_W-1:0]       cfg_data
);

  logic [mkp_pkg::HASH_W-1:0] hash_seed;
  logic [mkp_pkg::CNT_W-1:0]  client_count;
  logic [mkp_pkg::OWN_W-1:0]  local_index;
  logic [mkp_pkg::CNT_W-1:0]  count_eff;

  mkp_pkg::hash_beat_t hash_beat;
  mkp_pkg::rem_beat_t  rem_beat;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed    <= mkp_pkg::SEED_RESET;
      client_count <= mkp_pkg::COUNT_RESET;
      local_index  <= mkp_pkg::LOCAL_RESET;
    end else if (cfg_we) begin
      case (mkp_pkg::cfg_reg_t'(cfg_index))
        mkp_pkg::REG_HASH_SEED:    hash_seed    <= cfg_data;
        mkp_pkg::REG_CLIENT_COUNT: client_count <= cfg_data[mkp_pkg::CNT_W-1:0];
        mkp_pkg::REG_LOCAL_INDEX:  local_index  <= cfg_data[mkp_pkg::OWN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above 256 acts as 256
  always_comb begin
    if (client_count == '0) begin
      count_eff = mkp_pkg::CNT_W'(1);
    end else if (client_count[mkp_pkg::CNT_W-1] &&
                 client_count[mkp_pkg::CNT_W-2:0] != '0) begin
      count_eff = mkp_pkg::CNT_W'(256);
    end else begin
      count_eff = client_count;
    end
  end

  mkp_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start && !busy),
    .key_bytes (key_bytes),
    .seed      (hash_seed),
    .out       (hash_beat)
  );

  mkp_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .in      (hash_beat),
    .divisor (count_eff),
    .out     (rem_beat)
  );

  always_ff @(posedge clk) begin
    hash_value  <= rem_beat.hash;
    owner_index <= rem_beat.rem;
    is_local    <= (rem_beat.rem == local_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rem_beat.vld;
    end
  end

  `MKP_ASSERT_IMP(a_done_from_start, clk, rst, done, $past(start && !busy, mkp_pkg::LATENCY))
  `MKP_ASSERT_IMP(a_done_from_hash, clk, rst, done, $past(hash_beat.vld, mkp_pkg::DIV_STAGES + 1))
  `MKP_ASSERT_IMP(a_hash_carried, clk, rst, done, hash_value == $past(hash_beat.hash, mkp_pkg::DIV_STAGES + 1))

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the murmur3 key partitioner: keys go in through
// the start/busy handshake, each result is checked against a local hash
// and partition predictor, across several seed, client count and local
// index settings and several sender idling patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = mkp_pkg::LATENCY + 8;

  typedef struct packed {
    logic [mkp_pkg::HASH_W-1:0] hash;
    logic [mkp_pkg::OWN_W-1:0]  owner;
    logic                       hit;
  } part_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [mkp_pkg::KEY_W-1:0]     key_bytes = '0;
  logic                          done;
  logic [mkp_pkg::HASH_W-1:0]    hash_value;
  logic [mkp_pkg::OWN_W-1:0]     owner_index;
  logic                          is_local;
  logic                          cfg_we = 1'b0;
  logic [mkp_pkg::CFG_IDX_W-1:0] cfg_index = mkp_pkg::REG_HASH_SEED;
  logic [mkp_pkg::CFG_W-1:0]     cfg_data = '0;

  // copy of the register file as the block should see it
  logic [mkp_pkg::HASH_W-1:0] seed_reg = mkp_pkg::SEED_RESET;
  logic [mkp_pkg::CNT_W-1:0]  count_reg = mkp_pkg::COUNT_RESET;
  logic [mkp_pkg::OWN_W-1:0]  local_reg = mkp_pkg::LOCAL_RESET;

  logic [mkp_pkg::KEY_W-1:0] key_q[$];
  part_result_t              hash_due_q[$];
  part_result_t              next_due;
  logic                      taken = 1'b0;
  int                        idle_pct = 0;
  int                        errors = 0;
  int                        keys_sent = 0;
  int                        hashes_checked = 0;
  int                        local_hits = 0;
  int                        phases = 0;
  int                        cycle_count = 0;

  murmur3_key_partitioner dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .key_bytes  (key_bytes),
    .done       (done),
    .hash_value (hash_value),
    .owner_index(owner_index),
    .is_local   (is_local),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_lane(input logic [31:0] k);
    logic [31:0] m;
    m = k * mkp_pkg::MM_C1;
    m = rol32(m, 15);
    return m * mkp_pkg::MM_C2;
  endfunction

  function automatic part_result_t predict_partition(input logic [mkp_pkg::KEY_W-1:0] key);
    part_result_t res;
    logic [31:0]  h;
    logic [31:0]  k;
    logic [31:0]  cnt;
    int           pos;
    h = seed_reg;
    for (int b = 0; b < mkp_pkg::KEY_LEN / 4; b++) begin
      h = h ^ mix_lane(key[32*b +: 32]);
      h = rol32(h, 13);
      h = h * 32'd5 + mkp_pkg::MM_N;
    end
    pos = (mkp_pkg::KEY_LEN / 4) * 4;
    k = '0;
    for (int b = 0; b < mkp_pkg::KEY_LEN % 4; b++) begin
      k[8*b +: 8] = key[8*(pos + b) +: 8];
    end
    if (mkp_pkg::KEY_LEN % 4 != 0) begin
      h = h ^ mix_lane(k);
    end
    h = h ^ 32'(mkp_pkg::KEY_LEN);
    h = h ^ (h >> 16);
    h = h * mkp_pkg::MM_F1;
    h = h ^ (h >> 13);
    h = h * mkp_pkg::MM_F2;
    h = h ^ (h >> 16);
    cnt = 32'(count_reg);
    if (cnt == 0) begin
      cnt = 1;
    end
    if (cnt > 256) begin
      cnt = 256;
    end
    res.hash  = h;
    res.owner = 8'(h % cnt);
    res.hit   = (res.owner == local_reg);
    return res;
  endfunction

  function automatic logic [mkp_pkg::KEY_W-1:0] random_key();
    logic [mkp_pkg::KEY_W-1:0] key;
    int                        pick;
    pick = $urandom_range(9);
    key = {$urandom, $urandom};
    case (pick)
      6: begin
        key = '0;
        key[8*$urandom_range(7) +: 8] = 8'($urandom);
      end
      7: begin
        key = 64'd1 << $urandom_range(63);
        if ($urandom_range(1) == 1) begin
          key = ~key;
        end
      end
      8: begin
        if ($urandom_range(1) == 1) begin
          key[63:32] = '0;
        end else begin
          key[31:0] = '0;
        end
      end
      9: begin
        key = ($urandom_range(1) == 1) ? '1 : '0;
      end
      default: ;
    endcase
    return key;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
    errors++;
  endtask

  task automatic queue_key(input logic [mkp_pkg::KEY_W-1:0] key);
    key_q.insert(key_q.size(), key);
  endtask

  task automatic write_reg(input mkp_pkg::cfg_reg_t idx, input logic [mkp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= $urandom;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (key_q.size() != 0 || hash_due_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_random(input int n, input int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      queue_key(random_key());
    end
    wait_drained();
    phases++;
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (key_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start     <= 1'b1;
      key_bytes <= key_q[0];
    end else begin
      start     <= 1'b0;
      key_bytes <= {$urandom, $urandom};
    end
  end

  // item capture, register tracking and prediction
  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mkp_pkg::REG_HASH_SEED:    seed_reg = cfg_data[mkp_pkg::HASH_W-1:0];
          mkp_pkg::REG_CLIENT_COUNT: count_reg = cfg_data[mkp_pkg::CNT_W-1:0];
          mkp_pkg::REG_LOCAL_INDEX:  local_reg = cfg_data[mkp_pkg::OWN_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        hash_due_q.insert(hash_due_q.size(), predict_partition(key_bytes));
        void'(key_q.pop_front());
        taken <= 1'b1;
        keys_sent++;
      end else begin
        taken <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (hash_due_q.size() == 0) begin
        report_mismatch("unexpected result, hash", hash_value, '0);
      end else begin
        next_due = hash_due_q.pop_front();
        if (hash_value !== next_due.hash) begin
          report_mismatch("hash_value", hash_value, next_due.hash);
        end
        if (owner_index !== next_due.owner) begin
          report_mismatch("owner_index", 32'(owner_index), 32'(next_due.owner));
        end
        if (is_local !== next_due.hit) begin
          report_mismatch("is_local", 32'(is_local), 32'(next_due.hit));
        end
        if (next_due.hit) begin
          local_hits++;
        end
        hashes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, directed keys
    idle_pct = 0;
    queue_key(64'h0000_0000_0000_0000);
    queue_key(64'hffff_ffff_ffff_ffff);
    queue_key(64'h0000_0000_0000_0001);
    queue_key(64'h8000_0000_0000_0000);
    queue_key(64'h0000_0000_ffff_ffff);
    queue_key(64'hffff_ffff_0000_0000);
    queue_key(64'h0123_4567_89ab_cdef);
    queue_key(64'hfedc_ba98_7654_3210);
    queue_key(64'h5555_5555_5555_5555);
    queue_key(64'haaaa_aaaa_aaaa_aaaa);
    queue_key(64'h0000_0000_0000_0080);
    queue_key(64'h6564_6362_6179_656b);
    wait_drained();
    phases++;

    // extreme settings: widest partition set, top local index
    write_reg(mkp_pkg::REG_HASH_SEED, 32'h0000_0000);
    write_reg(mkp_pkg::REG_CLIENT_COUNT, 32'd256);
    write_reg(mkp_pkg::REG_LOCAL_INDEX, 32'd255);
    end_writes();
    queue_key(64'h0000_0000_0000_0000);
    queue_key(64'hffff_ffff_ffff_ffff);
    queue_key(64'h0000_0001_0000_0000);
    queue_key(64'h7fff_ffff_ffff_ffff);
    run_random(80, 0);

    // zero client count acts as one, every key is local
    write_reg(mkp_pkg::REG_HASH_SEED, 32'hffff_ffff);
    write_reg(mkp_pkg::REG_CLIENT_COUNT, 32'hffff_fe00);
    write_reg(mkp_pkg::REG_LOCAL_INDEX, 32'hffff_ff00);
    end_writes();
    queue_key(64'hffff_ffff_ffff_ffff);
    queue_key(64'h0000_0000_0000_0000);
    run_random(60, 83);

    // client count above range clamps to 256
    write_reg(mkp_pkg::REG_HASH_SEED, $urandom);
    write_reg(mkp_pkg::REG_CLIENT_COUNT, 32'd511);
    write_reg(mkp_pkg::REG_LOCAL_INDEX,
              ($urandom & 32'hffff_ff00) | 32'($urandom_range(255)));
    end_writes();
    run_random(100, 12);

    write_reg(mkp_pkg::REG_CLIENT_COUNT, 32'($urandom_range(256, 1)));
    write_reg(mkp_pkg::REG_LOCAL_INDEX, 32'($urandom_range(255)));
    end_writes();
    run_random(150, 0);

    write_reg(mkp_pkg::REG_HASH_SEED, $urandom);
    write_reg(mkp_pkg::REG_CLIENT_COUNT, 32'd3);
    write_reg(mkp_pkg::REG_LOCAL_INDEX, 32'd1);
    end_writes();
    run_random(120, 83);

    write_reg(mkp_pkg::REG_CLIENT_COUNT, ($urandom & 32'hffff_fe00) | 32'd257);
    write_reg(mkp_pkg::REG_LOCAL_INDEX, 32'($urandom_range(255)));
    end_writes();
    run_random(100, 12);

    write_reg(mkp_pkg::REG_HASH_SEED, mkp_pkg::SEED_RESET);
    write_reg(mkp_pkg::REG_CLIENT_COUNT, 32'd2);
    write_reg(mkp_pkg::REG_LOCAL_INDEX, 32'd1);
    end_writes();
    run_random(140, 0);

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d phases: %0d keys sent, %0d hashes checked, %0d local owners",
             phases, keys_sent, hashes_checked, local_hits);
    $display("settings swept seed, client count 0..511 and local index 0..255");
    if (errors == 0 && hash_due_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
